### sv/msc_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package msc_pkg;

  // Configuration space: one 32-bit register every 4 bytes.
  localparam int unsigned ADDR_W = 4;

  localparam logic [1:0] REG_GAIN     = 2'd0;
  localparam logic [1:0] REG_PKT_LEN  = 2'd1;
  localparam logic [1:0] REG_SLOT     = 2'd2;

  localparam logic [19:0] GAIN_RST    = 20'd65536;
  localparam logic [7:0]  PKT_LEN_RST = 8'd32;
  localparam logic        SLOT_RST    = 1'b0;

  localparam logic [7:0]  SAMPLE_MAX  = 8'd255;

  // Per-sample results of the conditioning datapath.
  typedef struct packed {
    logic signed [23:0] dc_nxt;
    logic [24:0]        mag;
    logic [7:0]         sample;
    logic               clip_low;
    logic               clip_high;
  } cond_t;

endpackage

`default_nettype wire

### sv/msc_cond.sv
`timescale 1ns / 1ps
`default_nettype none

module msc_cond (
  input  wire logic signed [23:0] s,
  input  wire logic signed [23:0] dc,
  input  wire logic [19:0]        gain,
  output msc_pkg::cond_t          res
);

  logic signed [30:0] dc_x;
  logic signed [30:0] s_x;
  logic signed [30:0] acc;
  logic signed [30:0] acc_adj;
  logic signed [23:0] dc_new;
  logic signed [24:0] c;
  logic signed [20:0] g;
  logic signed [45:0] prod;
  logic signed [29:0] scaled;
  logic signed [30:0] v;
  logic               lo;
  logic               hi;

  // dc*63 + s, then divide by 64 rounding toward zero
  assign dc_x    = 31'(dc);
  assign s_x     = 31'(s);
  assign acc     = (dc_x <<< 6) - dc_x + s_x;
  assign acc_adj = acc + (acc[30] ? 31'sd63 : 31'sd0);
  assign dc_new  = acc_adj[29:6];

  assign c = 25'(s) - 25'(dc_new);

  // Full-width product, floor shift by 16
  assign g      = $signed({1'b0, gain});
  assign prod   = c * g;
  assign scaled = prod[45:16];
  assign v      = 31'(scaled) + 31'sd128;

  assign lo = v[30];
  assign hi = !v[30] && (v[29:8] != 22'd0);

  always_comb begin
    res.dc_nxt    = dc_new;
    res.mag       = c[24] ? 25'(-c) : 25'(c);
    res.clip_low  = lo;
    res.clip_high = hi;
    if (lo) begin
      res.sample = 8'd0;
    end else if (hi) begin
      res.sample = msc_pkg::SAMPLE_MAX;
    end else begin
      res.sample = v[7:0];
    end
  end

endmodule

`default_nettype wire

### sv/mic_sample_conditioner_top.sv
`timescale 1ns / 1ps
`default_nettype none

// Microphone sample conditioner.
// Input channel: one I2S word (in_raw_word, in_slot) per transaction. Words
// whose slot differs from the active_slot register are taken and dropped.
// Output channel: one conditioned 8-bit sample per kept word, with clip
// flags, packet framing (end, sequence, position) and running statistics.
// Path: a kept word reaches the output through the input register, then the
// result register. Throughput: one word per cycle while the receiver does not
// stall; DC update, gain multiply and clamp all run in the single pass between
// the two registers, which also sets the cycle time.
// Stall: when the receiver stalls, the result register holds; the input
// register keeps accepting while it is empty, so in_stall rises only when
// both stages are full.
// Reset (rst_n low, synchronous): empties both stages, clears the DC
// estimate, peak, packet and counter state, and loads gain = 1.0,
// packet_len = 32, active_slot = 0. Registers sit at byte addresses 0, 4, 8.
module mic_sample_conditioner_top (
  input  wire logic                        clk,
  input  wire logic                        rst_n,

  input  wire logic                        in_valid,
  output logic                             in_stall,
  input  wire logic signed [31:0]          in_raw_word,
  input  wire logic                        in_slot,

  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [7:0]                       out_sample_out,
  output logic                             out_clip_low,
  output logic                             out_clip_high,
  output logic                             out_packet_end,
  output logic [15:0]                      out_packet_seq,
  output logic [7:0]                       out_packet_pos,
  output logic [23:0]                      out_peak_level,
  output logic [31:0]                      out_sample_count,
  output logic [31:0]                      out_low_clip_count,
  output logic [31:0]                      out_high_clip_count,

  input  wire logic                        cfg_psel,
  input  wire logic                        cfg_penable,
  input  wire logic                        cfg_pwrite,
  input  wire logic [msc_pkg::ADDR_W-1:0]  cfg_paddr,
  input  wire logic [31:0]                 cfg_pwdata,
  output logic [31:0]                      cfg_prdata,
  output logic                             cfg_pready
);

  // Configuration registers
  logic [19:0] gain_r;
  logic [7:0]  pkt_len_r;
  logic        slot_r;

  // Input stage
  logic               s1_vld_r;
  logic signed [23:0] s1_s_r;

  // Filter and statistics state
  logic signed [23:0] dc_r;
  logic [23:0]        peak_r;
  logic [7:0]         pkt_idx_r;
  logic [15:0]        pkt_cnt_r;
  logic [31:0]        smp_tot_r;
  logic [31:0]        lo_tot_r;
  logic [31:0]        hi_tot_r;

  // Result stage
  logic        out_vld_r;
  logic [7:0]  out_sample_r;
  logic        out_lo_r;
  logic        out_hi_r;
  logic        out_end_r;
  logic [15:0] out_seq_r;
  logic [7:0]  out_pos_r;

  logic [23:0] peak_nxt;
  logic [7:0]  pkt_idx_inc;
  logic        pkt_done;
  logic [7:0]  pkt_idx_nxt;
  logic [15:0] pkt_cnt_nxt;
  logic [31:0] lo_tot_nxt;
  logic [31:0] hi_tot_nxt;

  logic        adv;
  logic        in_take;
  logic        cfg_wr;

  msc_pkg::cond_t cond;

  msc_cond u_cond (
    .s    (s1_s_r),
    .dc   (dc_r),
    .gain (gain_r),
    .res  (cond)
  );

  // Move an item into the result register when that register is free or draining.
  assign adv      = s1_vld_r && (!out_vld_r || !out_stall);
  assign in_stall = s1_vld_r && !adv;
  assign in_take  = in_valid && !in_stall;

  // Configuration port: zero-wait APB slave
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite;

  always_comb begin
    unique case (cfg_paddr[3:2])
      msc_pkg::REG_GAIN:    cfg_prdata = {12'd0, gain_r};
      msc_pkg::REG_PKT_LEN: cfg_prdata = {24'd0, pkt_len_r};
      msc_pkg::REG_SLOT:    cfg_prdata = {31'd0, slot_r};
      default:              cfg_prdata = 32'd0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gain_r    <= msc_pkg::GAIN_RST;
      pkt_len_r <= msc_pkg::PKT_LEN_RST;
      slot_r    <= msc_pkg::SLOT_RST;
    end else if (cfg_wr) begin
      unique case (cfg_paddr[3:2])
        msc_pkg::REG_GAIN:    gain_r    <= cfg_pwdata[19:0];
        msc_pkg::REG_PKT_LEN: pkt_len_r <= cfg_pwdata[7:0];
        msc_pkg::REG_SLOT:    slot_r    <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // Input register: keep only words of the active slot, drop the low byte.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_vld_r <= 1'b0;
    end else if (in_take) begin
      s1_vld_r <= (in_slot == slot_r);
    end else if (adv) begin
      s1_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      s1_s_r <= in_raw_word[31:8];
    end
  end

  // Peak, packet framing and clip counting
  assign peak_nxt    = (cond.mag > {1'b0, peak_r}) ? cond.mag[23:0] : peak_r;
  assign pkt_idx_inc = pkt_idx_r + 8'd1;
  assign pkt_done    = (pkt_idx_inc >= pkt_len_r);
  assign pkt_idx_nxt = pkt_done ? 8'd0 : pkt_idx_inc;
  assign pkt_cnt_nxt = pkt_done ? pkt_cnt_r + 16'd1 : pkt_cnt_r;
  assign lo_tot_nxt  = lo_tot_r + {31'd0, cond.clip_low};
  assign hi_tot_nxt  = hi_tot_r + {31'd0, cond.clip_high};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dc_r      <= 24'sd0;
      peak_r    <= 24'd0;
      pkt_idx_r <= 8'd0;
      pkt_cnt_r <= 16'd0;
      smp_tot_r <= 32'd0;
      lo_tot_r  <= 32'd0;
      hi_tot_r  <= 32'd0;
    end else if (adv) begin
      dc_r      <= cond.dc_nxt;
      peak_r    <= peak_nxt;
      pkt_idx_r <= pkt_idx_nxt;
      pkt_cnt_r <= pkt_cnt_nxt;
      smp_tot_r <= smp_tot_r + 32'd1;
      lo_tot_r  <= lo_tot_nxt;
      hi_tot_r  <= hi_tot_nxt;
    end
  end

  // Result register: hold while stalled.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_vld_r <= 1'b0;
    end else if (adv) begin
      out_vld_r <= 1'b1;
    end else if (!out_stall) begin
      out_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_sample_r <= cond.sample;
      out_lo_r     <= cond.clip_low;
      out_hi_r     <= cond.clip_high;
      out_end_r    <= pkt_done;
      out_seq_r    <= pkt_cnt_r;
      out_pos_r    <= pkt_idx_r;
    end
  end

  // Running totals in the result come straight from the state, which only
  // moves together with the result register.
  assign out_valid           = out_vld_r;
  assign out_sample_out      = out_sample_r;
  assign out_clip_low        = out_lo_r;
  assign out_clip_high       = out_hi_r;
  assign out_packet_end      = out_end_r;
  assign out_packet_seq      = out_seq_r;
  assign out_packet_pos      = out_pos_r;
  assign out_peak_level      = peak_r;
  assign out_sample_count    = smp_tot_r;
  assign out_low_clip_count  = lo_tot_r;
  assign out_high_clip_count = hi_tot_r;

endmodule

`default_nettype wire
